// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the unmasker modules. Each module clocks
// its checks with clk and disables them while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

// ----- hw/rtl/wsu_pkg.sv -----
// ----------------------------------------------------------------------------
// wsu_pkg
// Types and constants for the frame unmasker.
// ----------------------------------------------------------------------------
package wsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 7;
  localparam int unsigned KeyN    = 4;
  localparam int unsigned KeyIdxW = 2;

  localparam logic [3:0]      OPC_TEXT = 4'h1;
  localparam logic [LenW-1:0] LEN_MAX  = 7'd125;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_KEY  = 2'd2,
    PH_PAY  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_UNMASKED   = 3'd2,
    ST_EXTENDED   = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             last_of_frame;
    status_t          status;
  } result_t;

endpackage

// ----- hw/rtl/websocket_frame_unmasker.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Client frame deframer: checks the header and length bytes, captures the
// four-byte mask key and emits unmasked text payload bytes.
// ----------------------------------------------------------------------------
// Takes one byte request per cycle while the result register is not held
// by back-pressure, and gives at most one result per byte through the input
// register, a combinational parse step and the result register. tuser on
// the result carries the status; a non-zero status always comes with tlast
// and zero data. Only short text frames with FIN set and a masked length up
// to 125 are passed; other frames yield one status result and the rest of
// the frame is dropped until the next byte flagged as frame start.
module websocket_frame_unmasker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] frame_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,   // last_of_frame
  output logic [2:0] m_axis_tuser    // [2:0] status
);

  logic              item_valid;
  wsu_pkg::in_item_t item;
  logic              out_ready;
  logic              consume;
  logic              res_valid;
  wsu_pkg::result_t  res;

  assign consume = item_valid && out_ready;

  wsu_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .consume      (consume),
    .item_valid   (item_valid),
    .item         (item)
  );

  wsu_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .fire     (consume),
    .item     (item),
    .res_valid(res_valid),
    .res      (res)
  );

  wsu_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (res_valid),
    .res          (res),
    .ready        (out_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// ----- hw/rtl/wsu_in_stage.sv -----
// ----------------------------------------------------------------------------
// wsu_in_stage
// Input register: holds one byte request until the parser consumes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsu_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // [7:0] data_byte
  input  logic              s_axis_tuser,  // [0] frame_start
  input  logic              consume,
  output logic              item_valid,
  output wsu_pkg::in_item_t item
);

  logic valid;

  assign s_axis_tready = !valid || consume;
  assign item_valid    = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.data_byte   <= s_axis_tdata;
      item.frame_start <= s_axis_tuser;
    end
  end

  `ASSERT_PROP(a_hold_until_consumed, valid && !consume |=> valid && $stable(item))
  `ASSERT_NEVER(a_consume_empty, consume && !valid)

endmodule

// ----- hw/rtl/wsu_parser.sv -----
// ----------------------------------------------------------------------------
// wsu_parser
// Frame header checks, mask key capture and payload unmasking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsu_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  wsu_pkg::in_item_t item,
  output logic              res_valid,
  output wsu_pkg::result_t  res
);

  wsu_pkg::phase_t phase, phase_next;

  logic [wsu_pkg::ByteW-1:0]   mask_key [wsu_pkg::KeyN];
  logic [wsu_pkg::KeyIdxW-1:0] key_cnt;
  logic [wsu_pkg::KeyIdxW-1:0] pay_idx;
  logic [wsu_pkg::LenW-1:0]    rem;

  logic [wsu_pkg::ByteW-1:0] b;
  logic [wsu_pkg::LenW-1:0]  len;
  logic [wsu_pkg::LenW-1:0]  rem_dec;
  logic                      hdr_ok;
  logic                      len_bad;
  logic                      key_done;

  assign b        = item.data_byte;
  assign len      = b[wsu_pkg::LenW-1:0];
  assign rem_dec  = rem - 7'd1;
  assign hdr_ok   = b[7] && (b[6:4] == 3'd0) && (b[3:0] == wsu_pkg::OPC_TEXT);
  assign len_bad  = !b[7] || (len > wsu_pkg::LEN_MAX);
  assign key_done = (key_cnt == 2'd3);

  // next state
  always_comb begin
    phase_next = phase;
    if (fire) begin
      if (item.frame_start) begin
        phase_next = hdr_ok ? wsu_pkg::PH_LEN : wsu_pkg::PH_IDLE;
      end else begin
        unique case (phase)
          wsu_pkg::PH_IDLE: phase_next = wsu_pkg::PH_IDLE;
          wsu_pkg::PH_LEN:  phase_next = len_bad ? wsu_pkg::PH_IDLE : wsu_pkg::PH_KEY;
          wsu_pkg::PH_KEY: begin
            if (key_done) begin
              phase_next = (rem == '0) ? wsu_pkg::PH_IDLE : wsu_pkg::PH_PAY;
            end
          end
          wsu_pkg::PH_PAY: begin
            if (rem_dec == '0) begin
              phase_next = wsu_pkg::PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  // result
  always_comb begin
    res_valid         = 1'b0;
    res.payload_byte  = '0;
    res.last_of_frame = 1'b1;
    res.status        = wsu_pkg::ST_OK;
    if (fire) begin
      if (item.frame_start) begin
        if (!hdr_ok) begin
          res_valid  = 1'b1;
          res.status = wsu_pkg::ST_BAD_HEADER;
        end
      end else begin
        unique case (phase)
          wsu_pkg::PH_IDLE: res_valid = 1'b0;
          wsu_pkg::PH_LEN: begin
            if (!b[7]) begin
              res_valid  = 1'b1;
              res.status = wsu_pkg::ST_UNMASKED;
            end else if (len > wsu_pkg::LEN_MAX) begin
              res_valid  = 1'b1;
              res.status = wsu_pkg::ST_EXTENDED;
            end
          end
          wsu_pkg::PH_KEY: begin
            if (key_done && rem == '0) begin
              res_valid  = 1'b1;
              res.status = wsu_pkg::ST_EMPTY;
            end
          end
          wsu_pkg::PH_PAY: begin
            res_valid         = 1'b1;
            res.payload_byte  = b ^ mask_key[pay_idx];
            res.last_of_frame = (rem_dec == '0);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wsu_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_cnt <= '0;
      pay_idx <= '0;
      rem     <= '0;
    end else if (fire && !item.frame_start) begin
      unique case (phase)
        wsu_pkg::PH_IDLE: rem <= rem;
        wsu_pkg::PH_LEN: begin
          if (!len_bad) begin
            rem     <= len;
            key_cnt <= '0;
          end
        end
        wsu_pkg::PH_KEY: begin
          key_cnt <= key_cnt + 2'd1;
          if (key_done) begin
            pay_idx <= '0;
          end
        end
        wsu_pkg::PH_PAY: begin
          pay_idx <= pay_idx + 2'd1;
          rem     <= rem_dec;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !item.frame_start && phase == wsu_pkg::PH_KEY) begin
      mask_key[key_cnt] <= b;
    end
  end

  `ASSERT_PROP(a_ok_only_in_payload, res_valid && res.status == wsu_pkg::ST_OK |-> phase == wsu_pkg::PH_PAY)
  `ASSERT_PROP(a_error_is_last_zero, res_valid && res.status != wsu_pkg::ST_OK |-> res.last_of_frame && res.payload_byte == '0)
  `ASSERT_PROP(a_last_goes_idle, res_valid && res.last_of_frame |=> phase == wsu_pkg::PH_IDLE)

endmodule

// ----- hw/rtl/wsu_out_stage.sv -----
// ----------------------------------------------------------------------------
// wsu_out_stage
// Result register toward the downstream stream.
// ----------------------------------------------------------------------------
module wsu_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wsu_pkg::result_t res,
  output logic             ready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] payload_byte
  output logic             m_axis_tlast,  // last_of_frame
  output logic [2:0]       m_axis_tuser   // [2:0] status
);

  logic             valid;
  wsu_pkg::result_t held;

  assign ready         = !valid || m_axis_tready;
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = held.payload_byte;
  assign m_axis_tlast  = held.last_of_frame;
  assign m_axis_tuser  = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// ----- tb/tb_websocket_frame_unmasker.sv -----
// ----------------------------------------------------------------------------
// tb_websocket_frame_unmasker
// Self-checking bench for the frame unmasker. A directed set of frames
// covers the header, length and empty-frame rejections and a short payload
// with key wrap. It is followed by random frames (well-formed, broken,
// abandoned and stray bytes) under several sender/receiver idling mixes and
// one long receiver hold-off. A scoreboard predicts every result from the
// accepted byte requests and checks the output stream in order.
// ----------------------------------------------------------------------------
module tb_websocket_frame_unmasker;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 300;

  class unmask_scoreboard;
    wsu_pkg::phase_t          phase;
    logic [31:0]              key;
    logic [1:0]               key_cnt;
    logic [wsu_pkg::LenW-1:0] remaining;
    logic [1:0]               pay_idx;
    wsu_pkg::result_t         expected_q[$];
    int unsigned              errors;

    function new();
      phase     = wsu_pkg::PH_IDLE;
      key       = '0;
      key_cnt   = '0;
      remaining = '0;
      pay_idx   = '0;
      errors    = 0;
    endfunction

    function void push_status(wsu_pkg::status_t st);
      wsu_pkg::result_t r;
      r = '{payload_byte: 8'h00, last_of_frame: 1'b1, status: st};
      expected_q.push_back(r);
      phase = wsu_pkg::PH_IDLE;
    endfunction

    function void note_request(logic [7:0] b, logic start);
      wsu_pkg::result_t r;
      logic [7:0]       k;
      if (start) begin
        if (b[7] && b[6:4] == 3'b000 && b[3:0] == wsu_pkg::OPC_TEXT) begin
          phase = wsu_pkg::PH_LEN;
        end else begin
          push_status(wsu_pkg::ST_BAD_HEADER);
        end
        return;
      end
      case (phase)
        wsu_pkg::PH_LEN: begin
          if (!b[7]) begin
            push_status(wsu_pkg::ST_UNMASKED);
          end else if (b[6:0] > wsu_pkg::LEN_MAX) begin
            push_status(wsu_pkg::ST_EXTENDED);
          end else begin
            remaining = b[6:0];
            key_cnt   = '0;
            key       = '0;
            phase     = wsu_pkg::PH_KEY;
          end
        end
        wsu_pkg::PH_KEY: begin
          key[key_cnt*8 +: 8] = b;
          if (key_cnt == 2'd3) begin
            key_cnt = '0;
            pay_idx = '0;
            if (remaining == '0) begin
              push_status(wsu_pkg::ST_EMPTY);
            end else begin
              phase = wsu_pkg::PH_PAY;
            end
          end else begin
            key_cnt = key_cnt + 2'd1;
          end
        end
        wsu_pkg::PH_PAY: begin
          k         = key[pay_idx*8 +: 8];
          pay_idx   = pay_idx + 2'd1;
          remaining = remaining - 1'b1;
          r = '{payload_byte: b ^ k, last_of_frame: (remaining == '0),
                status: wsu_pkg::ST_OK};
          expected_q.push_back(r);
          if (remaining == '0) begin
            phase = wsu_pkg::PH_IDLE;
          end
        end
        default: begin
          phase = wsu_pkg::PH_IDLE;
        end
      endcase
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [2:0] st);
      wsu_pkg::result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: payload_byte %0h last_of_frame %0b status %0d",
               data, last, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.payload_byte) begin
        $error("payload_byte mismatch: expected %0h, actual %0h", e.payload_byte, data);
        errors++;
      end
      if (last !== e.last_of_frame) begin
        $error("last_of_frame mismatch: expected %0b, actual %0b", e.last_of_frame, last);
        errors++;
      end
      if (st !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [2:0] m_axis_tuser;

  unmask_scoreboard sb;
  int unsigned      sent;
  int unsigned      cycles = 0;
  int unsigned      sender_idle_pct;
  int unsigned      rx_stall_pct;
  bit               hold_rx = 1'b0;
  bit               pressure_go;

  websocket_frame_unmasker i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (200) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] d, input logic start);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(d, start);
    sent++;
  endtask

  task automatic send_masked_frame(input int unsigned len, input bit allow_cut);
    logic [7:0] frame_q[$];
    int unsigned keep;
    frame_q.push_back({1'b1, 3'b000, wsu_pkg::OPC_TEXT});
    frame_q.push_back({1'b1, 7'(len)});
    repeat (wsu_pkg::KeyN + len) frame_q.push_back(8'($urandom));
    keep = frame_q.size();
    if (allow_cut && $urandom_range(9) == 0) begin
      keep = $urandom_range(frame_q.size() - 1, 1);
    end
    for (int i = 0; i < keep; i++) begin
      send_byte(frame_q[i], i == 0);
    end
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
    end else if (kind < 16) begin
      send_byte(8'($urandom), 1'b1);
      repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
    end else if (kind < 20) begin
      send_byte({1'b1, 3'b000, wsu_pkg::OPC_TEXT}, 1'b1);
      send_byte({1'b0, 7'($urandom)}, 1'b0);
    end else if (kind < 24) begin
      send_byte({1'b1, 3'b000, wsu_pkg::OPC_TEXT}, 1'b1);
      send_byte({1'b1, 7'($urandom_range(127, 126))}, 1'b0);
    end else begin
      pick = $urandom_range(19);
      if (pick == 0) len = 0;
      else if (pick == 1) len = wsu_pkg::LEN_MAX;
      else if (pick == 2) len = $urandom_range(wsu_pkg::LEN_MAX);
      else len = $urandom_range(12);
      send_masked_frame(len, 1'b1);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(2, 1)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    sb              = new();
    rst             = 1'b1;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    s_axis_tuser    = 1'b0;
    sent            = 0;
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    pressure_go     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: bad headers (FIN clear, RSV set, wrong opcode)
    send_byte(8'h01, 1'b1);
    send_byte(8'hC1, 1'b1);
    send_byte(8'h88, 1'b1);
    // mask bit clear
    send_byte(8'h81, 1'b1);
    send_byte(8'h05, 1'b0);
    // extended lengths
    send_byte(8'h81, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'hFF, 1'b0);
    // empty frame
    send_byte(8'h81, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    // five payload bytes (key index wraps), then a stray byte
    send_masked_frame(5, 1'b0);
    send_byte(8'hFF, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  pressure_go = 1'b1; end
        1: begin sender_idle_pct = 69; rx_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rx_stall_pct = 69; end
        default: begin sender_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      pick_loop: while (sent < (ph + 1) * PhaseItems + 25) begin
        send_random_frame();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
